### sv/mvf_pkg.sv
// shared types and constants for the multichannel volume fader
// no dependencies; used by mvf_div and multichannel_volume_fader_unit
package mvf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VOL_W     = 26;
    localparam int STEP_W    = 27;
    localparam int TGT_W     = 10;
    localparam int FRAMES_W  = 16;
    localparam int CHF_W     = 3;
    localparam int OP_W      = 3;
    localparam int REPORT_MAX = 8;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;
    localparam logic [FRAMES_W-1:0] DEFAULT_FADE_RESET = 16'd600;

    localparam logic [OP_W-1:0] OP_TICK         = 3'd0;
    localparam logic [OP_W-1:0] OP_FADE         = 3'd1;
    localparam logic [OP_W-1:0] OP_FADE_IN      = 3'd2;
    localparam logic [OP_W-1:0] OP_FADE_OUT     = 3'd3;
    localparam logic [OP_W-1:0] OP_FADE_OUT_STP = 3'd4;
    localparam logic [OP_W-1:0] OP_PLAY         = 3'd5;
    localparam logic [OP_W-1:0] OP_PLAY_FADE_IN = 3'd6;
    localparam logic [OP_W-1:0] OP_STOP_ALL     = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_DIV,
        ST_WRITE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [VOL_W-1:0]         volume;
        logic [TGT_W-1:0]         target;
        logic signed [STEP_W-1:0] step;
        logic                     fading;
        logic                     stop_at_end;
        logic                     playing;
    } t_entry;

    typedef struct packed {
        logic                start;
        logic [VOL_W-1:0]    dividend;
        logic [FRAMES_W-1:0] divisor;
    } t_div_req;

endpackage

### sv/mvf_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies; holds the per-channel fader state
module mvf_ram #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 8
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/mvf_div.sv
// restoring divider, one quotient bit per cycle, unsigned operands
// depends on mvf_pkg for widths and the request struct
module mvf_div
    import mvf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [VOL_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(VOL_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VOL_W - 1);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [FRAMES_W-1:0] r_rem, n_rem;
    logic [FRAMES_W-1:0] r_dvs, n_dvs;
    logic [VOL_W-1:0]    r_quo, n_quo;
    logic [FRAMES_W:0]   shifted;
    logic [FRAMES_W:0]   diff;
    logic                fits;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_quo   = r_quo;
        shifted = {r_rem, r_quo[VOL_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        fits    = (shifted >= {1'b0, r_dvs});
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
            n_quo  = i_req.dividend;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits back in FRAMES_W bits
            n_rem = fits ? diff[FRAMES_W-1:0] : shifted[FRAMES_W-1:0];
            n_quo = {r_quo[VOL_W-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

### sv/multichannel_volume_fader_unit.sv
// Multichannel linear volume fader. Each channel keeps a Q10.16 volume, a target, a signed
// per-tick step and play/fade/stop-at-end flags in a small ram (entries never written read
// as the reset state). One command is handled at a time, s_axis_tready is high only when
// idle, where a transaction is accepted. A tick or a play command then steps each channel
// through ram read, update, write back and status out. Every fade start runs the shared
// divider for (target - volume) / frames and collects its quotient before the write back.
// Status transactions leave through one output register; a stalled m_axis_tready holds the
// sequencer. Ticks and stop-all report channels 0..min(CHANNELS,8)-1.
// Depends on mvf_pkg, mvf_ram and mvf_div.
module multichannel_volume_fader_unit
    import mvf_pkg::*;
#(
    parameter int CHANNELS   = 8,
    parameter int MAX_VOLUME = 100
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write channel: default_fade_frames
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [FRAMES_W-1:0]   i_cfg_data,
    // command stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: channel[2:0], frames[18:3], target_volume[28:19], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: opcode[2:0]
    input  logic [OP_W-1:0]       s_axis_tuser,
    // status stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: out_channel[2:0], volume[12:3], fading[13], playing[14], stopped_now[15]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_W    = CH_IDX_W + CHF_W + 1;
    localparam int REPORTED = (CHANNELS < REPORT_MAX) ? CHANNELS : REPORT_MAX;
    localparam int ENT_W    = $bits(t_entry);
    localparam logic [CH_IDX_W-1:0] LAST_CH   = CH_IDX_W'(CHANNELS - 1);
    localparam logic [CH_IDX_W-1:0] LAST_REP  = CH_IDX_W'(REPORTED - 1);
    localparam logic [TGT_W-1:0]    MAX_TGT   = TGT_W'(MAX_VOLUME);
    localparam logic [VOL_W-1:0]    VOL_FULL  = {MAX_TGT, {FRAC_BITS{1'b0}}};

    t_state                r_state, n_state;
    logic [OP_W-1:0]       r_op, n_op;
    logic [CH_IDX_W-1:0]   r_ch, n_ch;
    logic [FRAMES_W-1:0]   r_frames, n_frames;
    logic [TGT_W-1:0]      r_tv, n_tv;
    logic                  r_multi, n_multi;
    t_entry                r_ent, n_ent;
    logic                  r_stopped, n_stopped;
    logic                  r_neg, n_neg;
    logic [CHANNELS-1:0]   r_valid, n_valid;
    logic [FRAMES_W-1:0]   r_cfg_frames;
    logic                  r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic                  r_out_last, n_out_last;

    t_entry                reset_ent;
    t_entry                ent_rd;
    t_entry                ent_mod;
    logic [ENT_W-1:0]      ram_rdata;
    t_div_req              div_req;
    logic                  div_done;
    logic [VOL_W-1:0]      div_q;

    logic [CHF_W-1:0]      in_ch;
    logic [FRAMES_W-1:0]   in_frames;
    logic [TGT_W-1:0]      in_tv;
    logic [CMP_W-1:0]      in_ch_ext;
    logic                  in_ch_ok;

    logic                  do_fade;
    logic [TGT_W-1:0]      fade_tgt;
    logic [FRAMES_W-1:0]   pick_n;
    logic signed [VOL_W+1:0] diff;
    logic signed [VOL_W+1:0] diff_abs;
    logic signed [VOL_W+1:0] tick_sum;
    logic [VOL_W-1:0]      tick_vol;
    logic [VOL_W-1:0]      tgt_fix;
    logic                  step_pos, step_neg;
    logic [STEP_W-1:0]     q_ext;
    logic                  report;

    assign reset_ent = '{volume: VOL_FULL, target: MAX_TGT, step: '0,
                         fading: 1'b0, stop_at_end: 1'b1, playing: 1'b0};

    assign in_ch     = s_axis_tdata[CHF_W-1:0];
    assign in_frames = s_axis_tdata[CHF_W+FRAMES_W-1:CHF_W];
    assign in_tv     = s_axis_tdata[CHF_W+FRAMES_W+TGT_W-1:CHF_W+FRAMES_W];
    assign in_ch_ext = CMP_W'(in_ch);
    assign in_ch_ok  = (in_ch_ext < CMP_W'(CHANNELS));

    assign ent_rd = r_valid[r_ch] ? t_entry'(ram_rdata) : reset_ent;
    assign report = !r_multi || ((CH_IDX_W+1)'(r_ch) < (CH_IDX_W+1)'(REPORTED));

    mvf_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CHANNELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_WRITE),
        .i_waddr (r_ch),
        .i_wdata (r_ent),
        .i_raddr (r_ch),
        .o_rdata (ram_rdata)
    );

    mvf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_ch        = r_ch;
        n_frames    = r_frames;
        n_tv        = r_tv;
        n_multi     = r_multi;
        n_ent       = r_ent;
        n_stopped   = r_stopped;
        n_neg       = r_neg;
        n_valid     = r_valid;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;

        ent_mod  = ent_rd;
        do_fade  = 1'b0;
        fade_tgt = '0;
        diff     = '0;
        diff_abs = '0;
        div_req  = '{start: 1'b0, dividend: '0, divisor: '0};

        pick_n = (r_frames != '0) ? r_frames :
                 (r_cfg_frames != '0) ? r_cfg_frames : FRAMES_W'(1);

        // tick arithmetic on the entry just read
        tgt_fix  = {ent_rd.target, {FRAC_BITS{1'b0}}};
        tick_sum = $signed({2'b00, ent_rd.volume}) + (VOL_W+2)'(ent_rd.step);
        if (tick_sum < 0) begin
            tick_vol = '0;
        end else if (tick_sum > $signed({2'b00, VOL_FULL})) begin
            tick_vol = VOL_FULL;
        end else begin
            tick_vol = tick_sum[VOL_W-1:0];
        end
        step_neg = ent_rd.step[STEP_W-1];
        step_pos = !step_neg && (ent_rd.step != '0);

        q_ext = {1'b0, div_q};

        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op      = s_axis_tuser;
                    n_tv      = in_tv;
                    n_stopped = 1'b0;
                    if (s_axis_tuser == OP_TICK || s_axis_tuser == OP_STOP_ALL) begin
                        n_multi  = 1'b1;
                        n_ch     = '0;
                        n_frames = '0;
                        n_state  = ST_READ;
                    end else begin
                        n_multi  = 1'b0;
                        n_ch     = in_ch_ext[CH_IDX_W-1:0];
                        n_frames = in_frames;
                        // out-of-range channel: command dropped, nothing reported
                        n_state  = in_ch_ok ? ST_READ : ST_IDLE;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_stopped = 1'b0;
                unique case (r_op)
                    OP_TICK: begin
                        if (ent_rd.fading) begin
                            ent_mod.volume = tick_vol;
                            if (step_pos && (tick_vol >= tgt_fix)) begin
                                ent_mod.volume = tgt_fix;
                                ent_mod.fading = 1'b0;
                            end else if (step_neg && (tick_vol <= tgt_fix)) begin
                                ent_mod.volume = tgt_fix;
                                ent_mod.fading = 1'b0;
                                if (ent_rd.stop_at_end) begin
                                    ent_mod.playing = 1'b0;
                                    n_stopped       = 1'b1;
                                end
                            end
                        end
                    end
                    OP_FADE: begin
                        do_fade  = 1'b1;
                        fade_tgt = (r_tv > MAX_TGT) ? MAX_TGT : r_tv;
                    end
                    OP_FADE_IN: begin
                        do_fade  = 1'b1;
                        fade_tgt = MAX_TGT;
                    end
                    OP_FADE_OUT: begin
                        do_fade             = 1'b1;
                        ent_mod.stop_at_end = 1'b0;
                    end
                    OP_FADE_OUT_STP, OP_STOP_ALL: begin
                        do_fade             = 1'b1;
                        ent_mod.stop_at_end = 1'b1;
                    end
                    OP_PLAY: begin
                        ent_mod.playing = 1'b1;
                        ent_mod.fading  = 1'b0;
                    end
                    OP_PLAY_FADE_IN: begin
                        ent_mod.volume  = '0;
                        ent_mod.playing = 1'b1;
                        do_fade         = 1'b1;
                        fade_tgt        = MAX_TGT;
                    end
                    default: begin
                        ent_mod = ent_rd;
                    end
                endcase
                diff     = $signed({2'b00, fade_tgt, {FRAC_BITS{1'b0}}})
                         - $signed({2'b00, ent_mod.volume});
                diff_abs = diff[VOL_W+1] ? -diff : diff;
                if (do_fade) begin
                    ent_mod.fading = 1'b1;
                    ent_mod.target = fade_tgt;
                    n_neg          = diff[VOL_W+1];
                    div_req        = '{start: 1'b1, dividend: diff_abs[VOL_W-1:0],
                                       divisor: pick_n};
                    n_state        = ST_DIV;
                end else begin
                    n_state = ST_WRITE;
                end
                n_ent = ent_mod;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_ent.step = r_neg ? -q_ext : q_ext;
                    n_state    = ST_WRITE;
                end
            end
            ST_WRITE: begin
                n_valid[r_ch] = 1'b1;
                n_state       = ST_EMIT;
            end
            ST_EMIT: begin
                if (!report || !r_out_valid || m_axis_tready) begin
                    if (report) begin
                        n_out_valid = 1'b1;
                        n_out_data  = {r_stopped, r_ent.playing, r_ent.fading,
                                       r_ent.volume[VOL_W-1:FRAC_BITS], CHF_W'(r_ch)};
                        n_out_last  = !r_multi || (r_ch == LAST_REP);
                    end
                    if (r_multi && (r_ch != LAST_CH)) begin
                        n_ch    = r_ch + 1'b1;
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
            r_cfg_frames <= DEFAULT_FADE_RESET;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_cfg_frames <= i_cfg_data;
            end
        end
        r_op       <= n_op;
        r_ch       <= n_ch;
        r_frames   <= n_frames;
        r_tv       <= n_tv;
        r_multi    <= n_multi;
        r_ent      <= n_ent;
        r_stopped  <= n_stopped;
        r_neg      <= n_neg;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
endmodule

### test/multichannel_volume_fader_unit_tb.sv
// testbench for multichannel_volume_fader_unit: directed and random fader commands with a
// cycle-free predictor in a small scoreboard class, bursty sender and stalling receiver
// depends on mvf_pkg and multichannel_volume_fader_unit
module multichannel_volume_fader_unit_tb;
    import mvf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS   = 8;
    localparam int MAX_VOLUME = 100;
    localparam longint VOL_FULL = longint'(MAX_VOLUME) << FRAC_BITS;

    typedef struct packed {
        logic [CHF_W-1:0] ch;
        logic [TGT_W-1:0] vol;
        logic             fading;
        logic             playing;
        logic             stopped;
        logic             last;
    } t_status_item;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_EVERY_FOURTH,
        RX_SPARSE
    } t_rx_mode;

    // per-channel fader state and the status transactions it predicts
    class fader_scoreboard;
        logic [VOL_W-1:0]         vol[CHANNELS];
        logic [TGT_W-1:0]         tgt[CHANNELS];
        logic signed [STEP_W-1:0] step[CHANNELS];
        bit                       fading[CHANNELS];
        bit                       stop_end[CHANNELS];
        bit                       playing[CHANNELS];
        logic [FRAMES_W-1:0]      fade_len_default;
        t_status_item             status_q[$];
        int                       errors;
        int                       checked;
        int                       stops_seen;

        function void clear();
            fade_len_default = DEFAULT_FADE_RESET;
            for (int c = 0; c < CHANNELS; c++) begin
                vol[c]      = VOL_FULL[VOL_W-1:0];
                tgt[c]      = TGT_W'(MAX_VOLUME);
                step[c]     = '0;
                fading[c]   = 1'b0;
                stop_end[c] = 1'b1;
                playing[c]  = 1'b0;
            end
            status_q.delete();
            errors = 0;
            checked = 0;
            stops_seen = 0;
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        function int unsigned fade_length(logic [FRAMES_W-1:0] frames);
            int unsigned n;
            n = 32'(frames);
            if (n == 0) n = 32'(fade_len_default);
            if (n == 0) n = 1;
            return n;
        endfunction

        function void begin_fade(int c, int unsigned n, int unsigned target);
            longint diff;
            longint q;
            if (target > MAX_VOLUME) target = MAX_VOLUME;
            diff = (longint'(target) << FRAC_BITS) - longint'(vol[c]);
            q = diff / longint'(n);
            fading[c] = 1'b1;
            tgt[c]    = target[TGT_W-1:0];
            step[c]   = q[STEP_W-1:0];
        endfunction

        // returns 1 when this tick finished a downward fade with stop-at-end set and stopped the channel
        function bit tick_channel(int c);
            longint v;
            longint t;
            if (!fading[c]) return 1'b0;
            v = longint'(vol[c]) + longint'(step[c]);
            if (v < 0) v = 0;
            if (v > VOL_FULL) v = VOL_FULL;
            t = longint'(tgt[c]) << FRAC_BITS;
            vol[c] = v[VOL_W-1:0];
            if (step[c] > 0 && v >= t) begin
                vol[c]    = t[VOL_W-1:0];
                fading[c] = 1'b0;
            end else if (step[c] < 0 && v <= t) begin
                vol[c]    = t[VOL_W-1:0];
                fading[c] = 1'b0;
                if (stop_end[c]) begin
                    playing[c] = 1'b0;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void push_status(int c, bit stopped, bit last);
            t_status_item s;
            s.ch      = c[CHF_W-1:0];
            s.vol     = vol[c][VOL_W-1:FRAC_BITS];
            s.fading  = fading[c];
            s.playing = playing[c];
            s.stopped = stopped;
            s.last    = last;
            if (stopped) stops_seen++;
            status_q.insert(status_q.size(), s);
        endfunction

        function void note_command(logic [OP_W-1:0] op, logic [CHF_W-1:0] ch,
                                   logic [FRAMES_W-1:0] frames, logic [TGT_W-1:0] tv);
            int c;
            bit st;
            c = int'(ch);
            if (op == OP_TICK || op == OP_STOP_ALL) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    st = 1'b0;
                    if (op == OP_TICK) begin
                        st = tick_channel(i);
                    end else begin
                        begin_fade(i, fade_length('0), 0);
                        stop_end[i] = 1'b1;
                    end
                    if (i < REPORT_MAX) push_status(i, st, (i + 1) == REPORT_MAX ||
                                                    (i + 1) == CHANNELS);
                end
                return;
            end
            if (c >= CHANNELS) return;
            case (op)
                OP_FADE: begin
                    begin_fade(c, fade_length(frames), 32'(tv));
                end
                OP_FADE_IN: begin
                    begin_fade(c, fade_length(frames), MAX_VOLUME);
                end
                OP_FADE_OUT: begin
                    begin_fade(c, fade_length(frames), 0);
                    stop_end[c] = 1'b0;
                end
                OP_FADE_OUT_STP: begin
                    begin_fade(c, fade_length(frames), 0);
                    stop_end[c] = 1'b1;
                end
                OP_PLAY: begin
                    playing[c] = 1'b1;
                    fading[c]  = 1'b0;
                end
                default: begin
                    vol[c]     = '0;
                    playing[c] = 1'b1;
                    fading[c]  = 1'b0;
                    begin_fade(c, fade_length(frames), MAX_VOLUME);
                end
            endcase
            push_status(c, 1'b0, 1'b1);
        endfunction

        function void compare_field(string what, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t ns: status %s mismatch, expected %0d, actual %0d",
                         $time, what, want, got);
            end
        endfunction

        function void check_status(logic [OUT_DATA_W-1:0] d, logic l);
            t_status_item want;
            if (status_q.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected status transaction, expected none, actual %h last %b",
                         $time, d, l);
                return;
            end
            want = status_q.pop_front();
            checked++;
            compare_field("channel", 32'(want.ch), 32'(d[2:0]));
            compare_field("volume", 32'(want.vol), 32'(d[12:3]));
            compare_field("fading", 32'(want.fading), 32'(d[13]));
            compare_field("playing", 32'(want.playing), 32'(d[14]));
            compare_field("stopped_now", 32'(want.stopped), 32'(d[15]));
            compare_field("last", 32'(want.last), 32'(l));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [FRAMES_W-1:0]   i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [OP_W-1:0]       s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    fader_scoreboard sb;
    int              n_cmds = 0;
    int              n_cfg = 0;
    t_rx_mode        rx_mode = RX_FREE;
    logic [15:0]     rx_cycle = '0;

    multichannel_volume_fader_unit #(
        .CHANNELS   (CHANNELS),
        .MAX_VOLUME (MAX_VOLUME)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // receiver stall pattern, switching style whenever the low six bits of rx_cycle are zero
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 16'd1;
        if (rx_cycle[5:0] == 6'd0) rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_FREE:         m_axis_tready <= 1'b1;
            RX_RANDOM:       m_axis_tready <= ($urandom_range(0, 9) < 7);
            RX_EVERY_FOURTH: m_axis_tready <= (rx_cycle[1:0] == 2'd3);
            default:         m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_status(m_axis_tdata, m_axis_tlast);
    end

    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [CHF_W-1:0] ch,
                            input logic [FRAMES_W-1:0] frames, input logic [TGT_W-1:0] tv);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, tv, frames, ch};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_command(op, ch, frames, tv);
        n_cmds++;
    endtask

    // gap with tvalid low, its length set by n; zero keeps the burst going
    task automatic pause_sender(input int n);
        if (n == 0) return;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic wait_drained(input int settle);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_fade_len(input logic [FRAMES_W-1:0] len);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.fade_len_default = len;
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random();
        logic [OP_W-1:0]     op;
        logic [FRAMES_W-1:0] frames;
        logic [TGT_W-1:0]    tv;
        int                  pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)      op = OP_TICK;
        else if (pick < 55) op = OP_FADE;
        else if (pick < 63) op = OP_FADE_IN;
        else if (pick < 70) op = OP_FADE_OUT;
        else if (pick < 78) op = OP_FADE_OUT_STP;
        else if (pick < 85) op = OP_PLAY;
        else if (pick < 95) op = OP_PLAY_FADE_IN;
        else                op = OP_STOP_ALL;
        // mostly short fades so that they finish within a few ticks
        pick = $urandom_range(0, 99);
        if (pick < 60)      frames = FRAMES_W'($urandom_range(1, 6));
        else if (pick < 75) frames = '0;
        else if (pick < 90) frames = FRAMES_W'($urandom_range(7, 64));
        else                frames = FRAMES_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 9) < 7) tv = TGT_W'($urandom_range(0, MAX_VOLUME));
        else                          tv = TGT_W'($urandom_range(0, 1023));
        send_cmd(op, CHF_W'($urandom_range(0, 7)), frames, tv);
    endtask

    task automatic run_random(input int count);
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 8);
            while (burst > 0 && left > 0) begin
                send_random();
                burst--;
                left--;
            end
            pause_sender((left == 0) ? 1 : $urandom_range(0, 6));
        end
    endtask

    task automatic run_directed();
        send_cmd(OP_TICK, 3'd0, 16'd0, 10'd0);
        send_cmd(OP_PLAY, 3'd0, 16'd0, 10'd0);
        // already at full volume: the fade in has a zero step and never ends
        send_cmd(OP_FADE_IN, 3'd0, 16'd0, 10'd0);
        send_cmd(OP_FADE, 3'd1, 16'hFFFF, 10'h3FF);
        send_cmd(OP_FADE_OUT, 3'd2, 16'd1, 10'd0);
        send_cmd(OP_FADE_OUT_STP, 3'd3, 16'd2, 10'd0);
        send_cmd(OP_PLAY, 3'd3, 16'd0, 10'd0);
        send_cmd(OP_PLAY_FADE_IN, 3'd4, 16'd3, 10'd0);
        send_cmd(OP_FADE, 3'd5, 16'hFFFF, 10'd0);
        send_cmd(OP_FADE, 3'd7, 16'd4, 10'd50);
        repeat (4) send_cmd(OP_TICK, 3'd0, 16'd0, 10'd0);
        send_cmd(OP_STOP_ALL, 3'd5, 16'd9, 10'd77);
        send_cmd(OP_TICK, 3'd0, 16'd0, 10'd0);
        send_cmd(OP_PLAY_FADE_IN, 3'd6, 16'hFFFF, 10'd0);
        send_cmd(OP_FADE, 3'd6, 16'd7, 10'd37);
        send_cmd(OP_TICK, 3'd7, 16'hAAAA, 10'h155);
        repeat (3) send_cmd(OP_TICK, 3'd0, 16'd0, 10'd0);
        send_cmd(OP_FADE, 3'd6, 16'h5555, 10'h2AA);
        send_cmd(OP_TICK, 3'd0, 16'd0, 10'd0);
        pause_sender(1);
    endtask

    initial begin
        sb = new;
        sb.clear();
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_TICK;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        wait_drained(8);
        write_fade_len(16'd1);
        run_random(45);
        wait_drained(8);
        write_fade_len(16'hFFFF);
        run_random(45);
        wait_drained(8);
        // zero length falls back to a single tick
        write_fade_len(16'd0);
        run_random(50);
        wait_drained(8);
        write_fade_len(FRAMES_W'($urandom_range(2, 12)));
        run_random(50);
        wait_drained(8);
        write_fade_len(FRAMES_W'($urandom_range(1, 65535)));
        run_random(45);
        wait_drained(40);

        $display("%0d commands accepted over %0d fade length settings", n_cmds, n_cfg);
        $display("%0d status transactions checked, %0d fade-out stops", sb.checked,
                 sb.stops_seen);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("timeout with %0d status transactions outstanding", sb.pending());
        $display("Some tests failed");
        $finish;
    end

endmodule
